>>> hw/rtl/smt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smt_pkg: shared types and constants for the sorted multiset table
// Operation and status codes, controller states, command bundle, widths.
// ----------------------------------------------------------------------------
package smt_pkg;

    localparam int SMT_CAPACITY = 64;
    localparam int DATA_W       = 32;
    localparam int OP_W         = 2;
    localparam int STATUS_W     = 2;
    localparam int OUT_CNT_W    = 7;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT          = 2'd0,
        OP_REMOVE_ONE      = 2'd1,
        OP_REMOVE_AT_LEAST = 2'd2,
        OP_COUNT           = 2'd3
    } smt_op_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_FULL      = 2'd1,
        STAT_NOT_FOUND = 2'd2
    } smt_status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_UPDATE,
        S_REPORT
    } smt_state_t;

    // controller -> datapath
    typedef struct packed {
        logic capture;  // latch request, compare value against every cell
        logic update;   // shift/write cells, update fill
        logic report;   // load result register
    } smt_cmd_t;

endpackage

>>> hw/rtl/smt_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smt_ctrl: sequencing for the sorted multiset table
// Three-state machine issuing capture/update/report; owns both handshakes.
// ----------------------------------------------------------------------------
module smt_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    output logic            m_valid,
    input  logic            m_ready,
    output smt_pkg::smt_cmd_t cmd
);
    import smt_pkg::*;

    smt_state_t state_reg, state_next;
    logic       m_valid_reg, m_valid_next;
    logic       out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        s_ready     = 1'b0;
        cmd         = '0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = S_UPDATE;
                end
            end
            S_UPDATE: begin
                cmd.update = 1'b1;
                state_next = S_REPORT;
            end
            S_REPORT: begin
                // table already updated, so next request may compare now
                if (out_free) begin
                    cmd.report = 1'b1;
                    s_ready    = 1'b1;
                    if (s_valid) begin
                        cmd.capture = 1'b1;
                        state_next  = S_UPDATE;
                    end else begin
                        state_next  = S_IDLE;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase

        if (cmd.report) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

endmodule

>>> hw/rtl/smt_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smt_datapath: cell row, comparators and result register
// Each cell compares against the broadcast value and shifts from a neighbor.
// ----------------------------------------------------------------------------
module smt_datapath #(
    parameter int CAPACITY = smt_pkg::SMT_CAPACITY
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  smt_pkg::smt_cmd_t                    cmd,
    input  logic [smt_pkg::OP_W-1:0]             s_op,
    input  logic signed [smt_pkg::DATA_W-1:0]    s_value,
    output logic [smt_pkg::STATUS_W-1:0]         m_status,
    output logic [smt_pkg::OUT_CNT_W-1:0]        m_match_count,
    output logic signed [smt_pkg::DATA_W-1:0]    m_largest,
    output logic [smt_pkg::OUT_CNT_W-1:0]        m_length
);
    import smt_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic signed [DATA_W-1:0] entry_reg  [CAPACITY];
    logic signed [DATA_W-1:0] entry_next [CAPACITY];
    logic [CNT_W-1:0]         fill_reg, fill_next;
    smt_op_t                  op_reg;
    logic signed [DATA_W-1:0] value_reg;
    logic [CAPACITY-1:0]      lt_reg, le_reg;   // thermometer codes
    logic [CAPACITY-1:0]      lt_next, le_next;
    smt_status_t              status_reg, status_next;
    logic [CNT_W-1:0]         match_reg, match_next;
    logic [CNT_W-1:0]         cnt_lt, cnt_le;
    logic                     full, found, do_ins, do_rem;
    logic [DATA_W-1:0]        largest_sel;
    logic [CNT_W+OUT_CNT_W-1:0] match_ext, fill_ext;

    // ones in a thermometer code = one past the index of its last one
    function automatic logic [CNT_W-1:0] therm_count(input logic [CAPACITY-1:0] t);
        logic [CNT_W-1:0] acc;
        acc = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (t[i] && (i == CAPACITY - 1 || !t[(i + 1) % CAPACITY])) begin
                acc = acc | CNT_W'(i + 1);
            end
        end
        return acc;
    endfunction

    // compare stage
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            lt_next[i] = (fill_reg > CNT_W'(i)) && (entry_reg[i] <  s_value);
            le_next[i] = (fill_reg > CNT_W'(i)) && (entry_reg[i] <= s_value);
        end
    end

    assign cnt_lt = therm_count(lt_reg);
    assign cnt_le = therm_count(le_reg);
    assign full   = (fill_reg == CNT_W'(CAPACITY));
    assign found  = |(le_reg & ~lt_reg);
    assign do_ins = (op_reg == OP_INSERT) && !full;
    assign do_rem = (op_reg == OP_REMOVE_ONE) && found;

    // cell update
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            entry_next[i] = entry_reg[i];
            if (do_ins && !lt_reg[i]) begin
                if (i == 0) begin
                    entry_next[i] = value_reg;
                end else if (lt_reg[(i + CAPACITY - 1) % CAPACITY]) begin
                    entry_next[i] = value_reg;
                end else begin
                    entry_next[i] = entry_reg[(i + CAPACITY - 1) % CAPACITY];
                end
            end else if (do_rem && !lt_reg[i] && i < CAPACITY - 1) begin
                entry_next[i] = entry_reg[(i + 1) % CAPACITY];
            end
        end
    end

    always_comb begin
        fill_next   = fill_reg;
        status_next = STAT_OK;
        match_next  = '0;
        if (cmd.update) begin
            unique case (op_reg)
                OP_INSERT: begin
                    if (full) status_next = STAT_FULL;
                    else      fill_next   = fill_reg + CNT_W'(1);
                end
                OP_REMOVE_ONE: begin
                    if (found) fill_next   = fill_reg - CNT_W'(1);
                    else       status_next = STAT_NOT_FOUND;
                end
                OP_REMOVE_AT_LEAST: fill_next = cnt_lt;
                OP_COUNT:           match_next = cnt_le - cnt_lt;
                default:            fill_next = fill_reg;
            endcase
        end
    end

    // entry at fill-1, zero when empty
    always_comb begin
        largest_sel = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (fill_reg == CNT_W'(i + 1)) begin
                largest_sel = largest_sel | entry_reg[i];
            end
        end
    end

    assign match_ext = {{OUT_CNT_W{1'b0}}, match_reg};
    assign fill_ext  = {{OUT_CNT_W{1'b0}}, fill_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
        end else begin
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg    <= smt_op_t'(s_op);
            value_reg <= s_value;
            lt_reg    <= lt_next;
            le_reg    <= le_next;
        end
        if (cmd.update) begin
            entry_reg  <= entry_next;
            status_reg <= status_next;
            match_reg  <= match_next;
        end
        if (cmd.report) begin
            m_status      <= status_reg;
            m_match_count <= match_ext[OUT_CNT_W-1:0];
            m_largest     <= largest_sel;
            m_length      <= fill_ext[OUT_CNT_W-1:0];
        end
    end

endmodule

>>> hw/rtl/sorted_multiset_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_multiset_table: bounded ascending multiset of signed 32-bit values
// Insert, remove-one, remove-at-least and count, one result per request.
// ----------------------------------------------------------------------------
// The table is a row of CAPACITY cells held in ascending order. A request is
// compared against every cell at the edge it is accepted, the cells shift or
// take the value in the next cycle, and the result register is then loaded
// in the reporting step. A new request is accepted in that same reporting
// cycle, but none before the compare-then-shift sequence across the cell
// row is through for the last one. If the result register is still held by
// m_ready low, the table waits in the reporting step. Every result carries a
// status (ok, full on insert, not found on remove-one), the number of equal
// entries for count (zero otherwise), the largest stored entry (zero when
// empty) and the length after the request. Length and count are reported in
// 7 bits. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module sorted_multiset_table #(
    parameter int CAPACITY = smt_pkg::SMT_CAPACITY
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [smt_pkg::OP_W-1:0]             s_op,
    input  logic signed [smt_pkg::DATA_W-1:0]    s_value,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [smt_pkg::STATUS_W-1:0]         m_status,
    output logic [smt_pkg::OUT_CNT_W-1:0]        m_match_count,
    output logic signed [smt_pkg::DATA_W-1:0]    m_largest,
    output logic [smt_pkg::OUT_CNT_W-1:0]        m_length
);
    import smt_pkg::*;

    smt_cmd_t cmd;

    // sequencing and both handshakes
    smt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    // cell row, fill count and result register
    smt_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .s_op          (s_op),
        .s_value       (s_value),
        .m_status      (m_status),
        .m_match_count (m_match_count),
        .m_largest     (m_largest),
        .m_length      (m_length)
    );

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the sorted multiset table
// Drives insert, remove-one, remove-at-least and count requests. A tracker
// keeps its own sorted copy of the multiset, predicts every result and checks
// the returned results in order, field by field. Both channels idle at
// random, with calm stretches where neither side holds back.
// ----------------------------------------------------------------------------
module tb_top;
    import smt_pkg::*;

    localparam int          CAP          = SMT_CAPACITY;
    localparam int unsigned RANDOM_ITEMS = 1550;
    localparam int          IDLE_LIMIT   = 2000;  // cycles with no handshake on either side
    localparam int          SETTLE       = 10;    // cycles after the last result

    typedef logic signed [DATA_W-1:0] key_t;

    localparam key_t KEY_MIN = 32'h8000_0000;
    localparam key_t KEY_MAX = 32'h7fff_ffff;

    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [OUT_CNT_W-1:0] match_count;
        logic [DATA_W-1:0]    largest;
        logic [OUT_CNT_W-1:0] length;
    } table_result_t;

    // request mix of one random phase
    typedef enum int {
        MIX_GROW,
        MIX_CHURN,
        MIX_SHRINK
    } mix_t;

    // ------------------------------------------------------------------------
    // Tracker: sorted copy of the multiset plus the results still owed
    // ------------------------------------------------------------------------
    class multiset_tracker;
        key_t            sorted_keys[CAP];
        int unsigned     fill_count;
        table_result_t   owed_results[$];
        int unsigned     errors;

        function new();
            fill_count = 0;
            errors     = 0;
        endfunction

        // first slot holding a key >= v (signed), fill_count if none
        function int unsigned first_at_least(key_t v);
            int unsigned i;
            i = 0;
            while (i < fill_count && sorted_keys[i] < v)
                i++;
            return i;
        endfunction

        function key_t pick_stored();
            if (fill_count == 0)
                return key_t'($urandom);
            return sorted_keys[$urandom_range(0, fill_count - 1)];
        endfunction

        function int unsigned outstanding();
            return owed_results.size();
        endfunction

        // apply one accepted request and queue the result it must produce
        function void note_request(smt_op_t op, key_t v);
            table_result_t want;
            int unsigned   pos;
            int unsigned   i;
            int unsigned   hits;
            want = '0;
            hits = 0;
            case (op)
                OP_INSERT: begin
                    if (fill_count >= CAP) begin
                        want.status = STAT_FULL;
                    end else begin
                        pos = first_at_least(v);
                        for (i = fill_count; i > pos; i--)
                            sorted_keys[i] = sorted_keys[i - 1];
                        sorted_keys[pos] = v;
                        fill_count++;
                    end
                end
                OP_REMOVE_ONE: begin
                    pos = fill_count;
                    for (i = 0; i < fill_count && pos == fill_count; i++)
                        if (sorted_keys[i] == v)
                            pos = i;
                    if (pos == fill_count) begin
                        want.status = STAT_NOT_FOUND;
                    end else begin
                        for (i = pos; i + 1 < fill_count; i++)
                            sorted_keys[i] = sorted_keys[i + 1];
                        fill_count--;
                    end
                end
                OP_REMOVE_AT_LEAST: begin
                    fill_count = first_at_least(v);
                end
                default: begin
                    for (i = 0; i < fill_count; i++)
                        if (sorted_keys[i] == v)
                            hits++;
                end
            endcase
            want.match_count = hits[OUT_CNT_W-1:0];
            want.largest     = (fill_count > 0) ? sorted_keys[fill_count - 1] : '0;
            want.length      = fill_count[OUT_CNT_W-1:0];
            owed_results.push_back(want);
        endfunction

        function void compare_field(string name, longint want, longint got);
            if (want != got) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(table_result_t got);
            table_result_t want;
            if (owed_results.size() == 0) begin
                $display("%0t: result with no request outstanding, status %0d length %0d",
                         $time, got.status, got.length);
                errors++;
                return;
            end
            want = owed_results.pop_front();
            compare_field("status", want.status, got.status);
            compare_field("match_count", want.match_count, got.match_count);
            compare_field("largest", $signed(want.largest), $signed(got.largest));
            compare_field("length", want.length, got.length);
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT and its signals
    // ------------------------------------------------------------------------
    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    logic [OP_W-1:0]       s_op;
    key_t                  s_value;
    logic                  m_valid;
    logic                  m_ready;
    logic [STATUS_W-1:0]   m_status;
    logic [OUT_CNT_W-1:0]  m_match_count;
    key_t                  m_largest;
    logic [OUT_CNT_W-1:0]  m_length;

    sorted_multiset_table i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_op          (s_op),
        .s_value       (s_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_match_count (m_match_count),
        .m_largest     (m_largest),
        .m_length      (m_length)
    );

    multiset_tracker tracker;
    bit              calm;          // no idling on either side while set
    int              ready_left;    // cycles left in the current m_ready state
    int              quiet_cycles;  // cycles without any handshake
    table_result_t   seen;

    always #1 aclk = ~aclk;

    // Gap length for either side: mostly none or short, now and then long.
    function automatic int pick_gap();
        int roll;
        if (calm)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 50)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 95)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // Result side back-pressure. m_ready is read here before the edge updates it,
    // so a stall is only ever entered while m_ready is high.
    always @(posedge aclk) begin
        if (ready_left > 0) begin
            ready_left--;
        end else if (calm) begin
            m_ready <= 1'b1;
        end else if (m_ready && $urandom_range(0, 1) == 1) begin
            m_ready    <= 1'b0;
            ready_left = pick_gap();
        end else begin
            m_ready    <= 1'b1;
            ready_left = $urandom_range(0, 7);
        end
    end

    // Monitor: requests and results are taken at the edge where they are
    // accepted, using the values held just before that edge. Also the watchdog.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                tracker.note_request(smt_op_t'(s_op), s_value);
            if (m_valid && m_ready) begin
                seen.status      = m_status;
                seen.match_count = m_match_count;
                seen.largest     = m_largest;
                seen.length      = m_length;
                tracker.check_result(seen);
            end
            if ((s_valid && s_ready) || (m_valid && m_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= IDLE_LIMIT) begin
                $display("%0t: no handshake for %0d cycles, %0d results outstanding",
                         $time, IDLE_LIMIT, tracker.outstanding());
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------

    // One request: optional gap, then hold valid until the handshake.
    task automatic send_request(smt_op_t op, key_t v);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_op    <= op;
        s_value <= v;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
    endtask

    // Hold off the request side until every result owed has arrived.
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (tracker.outstanding() != 0)
            @(posedge aclk);
    endtask

    // Keys: small range for duplicates, extremes, stored keys for hits, and
    // fully random patterns so every bit toggles.
    function automatic key_t pick_key();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 40)
            return key_t'($urandom_range(0, 16)) - 8;
        if (roll < 50) begin
            case ($urandom_range(0, 6))
                0: return KEY_MIN;
                1: return KEY_MIN + 1;
                2: return -1;
                3: return 0;
                4: return 1;
                5: return KEY_MAX - 1;
                default: return KEY_MAX;
            endcase
        end
        if (roll < 80)
            return tracker.pick_stored();
        return key_t'($urandom);
    endfunction

    function automatic smt_op_t pick_op(mix_t mix);
        int roll;
        int ins_lim;
        int rem_lim;
        int cut_lim;
        roll = $urandom_range(0, 99);
        case (mix)
            MIX_GROW: begin
                ins_lim = 80; rem_lim = 85; cut_lim = 87;
            end
            MIX_CHURN: begin
                ins_lim = 35; rem_lim = 60; cut_lim = 72;
            end
            default: begin
                ins_lim = 10; rem_lim = 50; cut_lim = 75;
            end
        endcase
        if (roll < ins_lim)
            return OP_INSERT;
        if (roll < rem_lim)
            return OP_REMOVE_ONE;
        if (roll < cut_lim)
            return OP_REMOVE_AT_LEAST;
        return OP_COUNT;
    endfunction

    task automatic run_directed();
        // empty table: count, miss on remove-one, cut with nothing stored
        send_request(OP_COUNT, 0);
        send_request(OP_REMOVE_ONE, 5);
        send_request(OP_REMOVE_AT_LEAST, 0);
        // extremes and neighbors, out of order
        send_request(OP_INSERT, KEY_MAX);
        send_request(OP_INSERT, KEY_MIN);
        send_request(OP_INSERT, 0);
        send_request(OP_INSERT, -1);
        send_request(OP_INSERT, 1);
        // equal keys
        send_request(OP_INSERT, 7);
        send_request(OP_INSERT, 7);
        send_request(OP_INSERT, 7);
        send_request(OP_COUNT, 7);
        send_request(OP_COUNT, KEY_MIN);
        send_request(OP_COUNT, 3);
        send_request(OP_REMOVE_ONE, 7);
        send_request(OP_COUNT, 7);
        send_request(OP_REMOVE_ONE, 100);
        // removing the largest moves the reported maximum
        send_request(OP_REMOVE_ONE, KEY_MAX);
        send_request(OP_REMOVE_AT_LEAST, 1);
        send_request(OP_REMOVE_AT_LEAST, KEY_MAX);
        send_request(OP_REMOVE_ONE, KEY_MIN);
        // cut at the minimum empties the table
        send_request(OP_REMOVE_AT_LEAST, KEY_MIN);
        send_request(OP_COUNT, 0);
        send_request(OP_INSERT, 32'h5555_5555);
        send_request(OP_INSERT, 32'haaaa_aaaa);
    endtask

    // Phases of random length with a random mix; the grow mix fills the
    // table so inserts also hit the full case.
    task automatic run_random();
        int unsigned sent;
        int unsigned phase_len;
        int unsigned k;
        mix_t        mix;
        smt_op_t     op;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            mix       = mix_t'($urandom_range(0, 2));
            calm      = ($urandom_range(0, 4) == 0);
            phase_len = $urandom_range(40, 160);
            if (phase_len > RANDOM_ITEMS - sent)
                phase_len = RANDOM_ITEMS - sent;
            for (k = 0; k < phase_len; k++) begin
                op = pick_op(mix);
                send_request(op, pick_key());
            end
            sent += phase_len;
            if ($urandom_range(0, 2) == 0)
                drain();
        end
        calm = 1'b0;
    endtask

    initial begin
        tracker       = new();
        aclk          = 1'b0;
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_op          = OP_INSERT;
        s_value       = '0;
        m_ready       = 1'b0;
        calm          = 1'b0;
        ready_left    = 0;
        quiet_cycles  = 0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        run_directed();
        drain();
        run_random();
        drain();
        repeat (SETTLE) @(posedge aclk);

        if (tracker.errors == 0 && tracker.outstanding() == 0) begin
            $display("Simulation PASSED");
        end else begin
            if (tracker.outstanding() != 0)
                $display("%0t: %0d results never arrived", $time, tracker.outstanding());
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/smt_pkg.sv
hw/rtl/smt_ctrl.sv
hw/rtl/smt_datapath.sv
hw/rtl/sorted_multiset_table.sv
sim/tb_top.sv
